/* sv/mgrt_pkg.sv */
package mgrt_pkg;

    localparam int CAPACITY = 32;
    localparam int SLOT_W   = 12;
    localparam int GUARD_W  = 4;
    localparam int STAT_W   = 2;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(3);

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_LIST
    } state_t;

    typedef struct packed {
        logic start;
        logic check_step;
        logic decide;
        logic list_step;
    } mgrt_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic check_last;
        logic list_last;
        logic out_free;
    } mgrt_sts_t;

endpackage

/* sv/mgrt_ctrl.sv */
module mgrt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  mgrt_pkg::mgrt_sts_t sts,
    output mgrt_pkg::mgrt_cmd_t cmd
);

    mgrt_pkg::state_t state_reg;
    mgrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mgrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            mgrt_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    // An empty table has nothing to scan.
                    state_next = sts.count_zero ? mgrt_pkg::S_DECIDE : mgrt_pkg::S_CHECK;
                end
            end
            mgrt_pkg::S_CHECK:
            begin
                cmd.check_step = 1'b1;
                if (sts.check_last)
                begin
                    state_next = mgrt_pkg::S_DECIDE;
                end
            end
            mgrt_pkg::S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = mgrt_pkg::S_LIST;
            end
            mgrt_pkg::S_LIST:
            begin
                if (sts.out_free)
                begin
                    cmd.list_step = 1'b1;
                    if (sts.list_last)
                    begin
                        state_next = mgrt_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mgrt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/mgrt_datapath.sv */
module mgrt_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mgrt_pkg::mgrt_cmd_t                 cmd,
    output mgrt_pkg::mgrt_sts_t                 sts,
    input  logic [mgrt_pkg::SLOT_W-1:0]         req_slot,
    input  logic                                cfg_wr_en,
    input  logic [mgrt_pkg::GUARD_W-1:0]        cfg_wr_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [mgrt_pkg::SLOT_W-1:0]         listed_slot,
    output logic [mgrt_pkg::STAT_W-1:0]         status,
    output logic                                last_of_run
);

    localparam logic [mgrt_pkg::CNT_W-1:0] CAP_C = mgrt_pkg::CNT_W'(mgrt_pkg::CAPACITY);
    localparam logic [mgrt_pkg::CNT_W-1:0] ONE_C = mgrt_pkg::CNT_W'(1);

    // Sorted slot storage, one write and one registered read per cycle.
    logic [mgrt_pkg::SLOT_W-1:0] mem [mgrt_pkg::CAPACITY];
    logic [mgrt_pkg::SLOT_W-1:0] rd_data_reg;
    logic                        rd_en;
    logic [mgrt_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic [mgrt_pkg::ADDR_W-1:0] wr_addr;
    logic [mgrt_pkg::SLOT_W-1:0] wr_data;

    logic [mgrt_pkg::GUARD_W-1:0] guard_reg;
    logic [mgrt_pkg::SLOT_W-1:0]  req_reg;
    logic [mgrt_pkg::CNT_W-1:0]   n_reg, n_next;
    logic [mgrt_pkg::CNT_W-1:0]   k_reg, k_next;
    logic [mgrt_pkg::CNT_W-1:0]   pos_reg, pos_next;
    logic [mgrt_pkg::CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic                         conflict_reg, conflict_next;
    logic                         ins_reg, ins_next;
    mgrt_pkg::status_t            run_stat_reg, run_stat_next;

    logic                         out_valid_reg;
    logic [mgrt_pkg::SLOT_W-1:0]  listed_slot_reg;
    mgrt_pkg::status_t            status_reg;
    logic                         last_reg;

    logic [mgrt_pkg::SLOT_W-1:0]  gap;
    logic                         near;
    logic                         at_pos;
    logic [mgrt_pkg::SLOT_W-1:0]  elem;
    logic                         ptr_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        gap = (rd_data_reg > req_reg) ? (rd_data_reg - req_reg) : (req_reg - rd_data_reg);
        near = gap <= mgrt_pkg::SLOT_W'(guard_reg);
        at_pos = ins_reg && (k_reg == pos_reg);
        // Past the insert point the listing runs one entry behind the reads.
        elem = at_pos ? req_reg : rd_data_reg;
        ptr_ok = rd_ptr_reg < CAP_C;
    end

    always_comb
    begin
        n_next        = n_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        rd_ptr_next   = rd_ptr_reg;
        conflict_next = conflict_reg;
        ins_next      = ins_reg;
        run_stat_next = run_stat_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg[mgrt_pkg::ADDR_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = k_reg[mgrt_pkg::ADDR_W-1:0];
        wr_data       = elem;

        if (cmd.start)
        begin
            rd_en         = 1'b1;
            rd_addr       = '0;
            rd_ptr_next   = ONE_C;
            k_next        = '0;
            pos_next      = '0;
            conflict_next = 1'b0;
            ins_next      = 1'b0;
        end

        if (cmd.check_step)
        begin
            rd_en       = ptr_ok;
            rd_ptr_next = rd_ptr_reg + ONE_C;
            k_next      = k_reg + ONE_C;
            if (near)
            begin
                conflict_next = 1'b1;
            end
            if (rd_data_reg < req_reg)
            begin
                pos_next = pos_reg + ONE_C;
            end
        end

        if (cmd.decide)
        begin
            rd_en       = 1'b1;
            rd_addr     = '0;
            rd_ptr_next = ONE_C;
            k_next      = '0;
            if (conflict_reg)
            begin
                run_stat_next = mgrt_pkg::ST_CONFLICT;
            end
            else if (n_reg >= CAP_C)
            begin
                run_stat_next = mgrt_pkg::ST_FULL;
            end
            else
            begin
                run_stat_next = mgrt_pkg::ST_ACCEPTED;
                ins_next      = 1'b1;
                n_next        = n_reg + ONE_C;
            end
        end

        if (cmd.list_step)
        begin
            k_next = k_reg + ONE_C;
            // The insert point takes no read: the pending entry moves up one place.
            if (!at_pos)
            begin
                rd_en       = ptr_ok;
                rd_ptr_next = rd_ptr_reg + ONE_C;
            end
            wr_en = ins_reg && (k_reg >= pos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg     <= mgrt_pkg::GUARD_RESET;
            n_reg         <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            rd_ptr_reg    <= '0;
            conflict_reg  <= 1'b0;
            ins_reg       <= 1'b0;
            run_stat_reg  <= mgrt_pkg::ST_ACCEPTED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                guard_reg <= cfg_wr_data;
            end
            n_reg        <= n_next;
            k_reg        <= k_next;
            pos_reg      <= pos_next;
            rd_ptr_reg   <= rd_ptr_next;
            conflict_reg <= conflict_next;
            ins_reg      <= ins_next;
            run_stat_reg <= run_stat_next;
            if (cmd.list_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= req_slot;
        end
        if (cmd.list_step)
        begin
            listed_slot_reg <= elem;
            status_reg      <= run_stat_reg;
            last_reg        <= sts.list_last;
        end
    end

    always_comb
    begin
        sts.count_zero = n_reg == '0;
        sts.check_last = (k_reg + ONE_C) == n_reg;
        sts.list_last  = (k_reg + ONE_C) == n_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign listed_slot = listed_slot_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CAP_C)
        else $error("entry count above capacity");

    a_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
        ins_reg |-> pos_reg < n_reg)
        else $error("insert position outside the table");

    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && (conflict_reg || n_reg >= CAP_C) |=> $stable(n_reg))
        else $error("refused request changed the entry count");

    a_listing_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_step && k_reg != '0 |-> elem > listed_slot_reg)
        else $error("listing is not strictly ascending");

endmodule

/* sv/min_gap_reservation_table_top.sv */
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  req_slot
// listing   out        out_valid/out_stall  listed_slot, status, last_of_run
// config    in         cfg_wr_en            cfg_wr_data (guard distance)
//
// A request runs a start step, a scan of the n stored slots for a conflict and the
// insert position, a decide step, and one listed beat per table entry. The single read
// port of the slot memory serves both scan and listing, each reading at most one entry
// per cycle, the listing only while the output is free. Reset empties the table and sets
// the guard distance to 3. A stall on the listing holds the sequencer; the next request
// is taken while the final beat still waits in the output register.
module min_gap_reservation_table_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mgrt_pkg::SLOT_W-1:0]        req_slot,
    input  logic                               cfg_wr_en,
    input  logic [mgrt_pkg::GUARD_W-1:0]       cfg_wr_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mgrt_pkg::SLOT_W-1:0]        listed_slot,
    output logic [mgrt_pkg::STAT_W-1:0]        status,
    output logic                               last_of_run
);

    mgrt_pkg::mgrt_cmd_t cmd;
    mgrt_pkg::mgrt_sts_t sts;

    mgrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mgrt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_slot    (req_slot),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .listed_slot (listed_slot),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule
